// File: design/bcc_pkg.sv
// Shared types and constants for the basic computer control step block.
package bcc_pkg;

    localparam logic [2:0] ACT_TICK     = 3'd0;
    localparam logic [2:0] ACT_LOAD     = 3'd1;
    localparam logic [2:0] ACT_READ     = 3'd2;
    localparam logic [2:0] ACT_INPUT    = 3'd3;
    localparam logic [2:0] ACT_OUT_FREE = 3'd4;

    localparam logic [2:0] OP_AND    = 3'd0;
    localparam logic [2:0] OP_ADD    = 3'd1;
    localparam logic [2:0] OP_LDA    = 3'd2;
    localparam logic [2:0] OP_STA    = 3'd3;
    localparam logic [2:0] OP_BUN    = 3'd4;
    localparam logic [2:0] OP_BSA    = 3'd5;
    localparam logic [2:0] OP_ISZ    = 3'd6;
    localparam logic [2:0] OP_REG_IO = 3'd7;

    localparam logic [2:0] T0 = 3'd0;
    localparam logic [2:0] T1 = 3'd1;
    localparam logic [2:0] T2 = 3'd2;
    localparam logic [2:0] T3 = 3'd3;
    localparam logic [2:0] T4 = 3'd4;
    localparam logic [2:0] T5 = 3'd5;
    localparam logic [2:0] T6 = 3'd6;

    localparam logic [11:0] RR_HLT = 12'h001;
    localparam logic [11:0] RR_SZE = 12'h002;
    localparam logic [11:0] RR_SZA = 12'h004;
    localparam logic [11:0] RR_SNA = 12'h008;
    localparam logic [11:0] RR_SPA = 12'h010;
    localparam logic [11:0] RR_INC = 12'h020;
    localparam logic [11:0] RR_CIL = 12'h040;
    localparam logic [11:0] RR_CIR = 12'h080;
    localparam logic [11:0] RR_CME = 12'h100;
    localparam logic [11:0] RR_CMA = 12'h200;
    localparam logic [11:0] RR_CLE = 12'h400;
    localparam logic [11:0] RR_CLA = 12'h800;

    localparam logic [11:0] IO_IOF = 12'h040;
    localparam logic [11:0] IO_ION = 12'h080;
    localparam logic [11:0] IO_SKO = 12'h100;
    localparam logic [11:0] IO_SKI = 12'h200;
    localparam logic [11:0] IO_OUT = 12'h400;
    localparam logic [11:0] IO_INP = 12'h800;

    typedef struct packed {
        logic [2:0]  action;
        logic [11:0] mem_addr;
        logic [15:0] mem_data;
        logic [7:0]  in_char;
    } t_item;

    typedef struct packed {
        logic        halted;
        logic        out_valid;
        logic [7:0]  out_char;
        logic [15:0] read_data;
        logic [11:0] prog_counter;
        logic [15:0] accum;
        logic        extend_bit;
        logic        int_enable;
    } t_result;

    typedef struct packed {
        logic        wr_en;
        logic [11:0] addr;
        logic [15:0] data;
    } t_mem_wr;

    typedef struct packed {
        logic        rd_en;
        logic [11:0] rd_addr;
        logic        wr_en;
        logic [11:0] wr_addr;
        logic [15:0] wr_data;
    } t_mem_req;

endpackage

// File: design/bcc_mem.sv
// Main memory with registered read, write bypass and a clearing pass after reset.
module bcc_mem #(
    parameter int MEM_WORDS = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bcc_pkg::t_mem_req i_req,
    output logic [15:0]       o_rd_data,
    output logic              o_busy
);
    localparam int IDX_W = $clog2(MEM_WORDS);
    localparam logic [16:0] MW = 17'(MEM_WORDS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MEM_WORDS - 1);

    function automatic logic [IDX_W-1:0] f_idx(input logic [11:0] a);
        logic [16:0] x;
        x = {5'd0, a};
        for (int k = 4; k >= 0; k--) begin
            if (x >= (MW << k)) begin
                x = x - (MW << k);
            end
        end
        return x[IDX_W-1:0];
    endfunction

    logic [15:0]      r_mem [MEM_WORDS];
    logic [15:0]      r_rd_data;
    logic             r_clearing;
    logic [IDX_W-1:0] r_clr_idx;

    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] wr_idx;
    logic             wr_en;
    logic [IDX_W-1:0] wr_sel;
    logic [15:0]      wr_data;

    assign rd_idx  = f_idx(i_req.rd_addr);
    assign wr_idx  = f_idx(i_req.wr_addr);
    assign wr_en   = r_clearing || i_req.wr_en;
    assign wr_sel  = r_clearing ? r_clr_idx : wr_idx;
    assign wr_data = r_clearing ? 16'd0 : i_req.wr_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clearing) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == LAST_IDX) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_sel] <= wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= (i_req.wr_en && (wr_idx == rd_idx)) ? i_req.wr_data : r_mem[rd_idx];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_clearing;

endmodule

// File: design/bcc_core.sv
// Architectural registers and one timing step of the computer per transaction.
module bcc_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  bcc_pkg::t_item   i_item,
    input  logic [15:0]      i_rd_data,
    output bcc_pkg::t_result o_result,
    output bcc_pkg::t_mem_wr o_mem_wr,
    output logic [11:0]      o_next_addr
);
    logic [11:0] r_addr, n_addr;
    logic [11:0] r_pc, n_pc;
    logic [15:0] r_dr, n_dr;
    logic [15:0] r_ac, n_ac;
    logic [15:0] r_ir, n_ir;
    logic [15:0] r_tr, n_tr;
    logic [7:0]  r_inpr, n_inpr;
    logic [2:0]  r_sc, n_sc;
    logic [2:0]  r_opc, n_opc;
    logic        r_s, n_s;
    logic        r_fgi, n_fgi;
    logic        r_fgo, n_fgo;
    logic        r_ien, n_ien;
    logic        r_r, n_r;
    logic        r_i, n_i;
    logic        r_e, n_e;

    logic        ov;
    logic [16:0] sum;
    bcc_pkg::t_mem_wr wr;

    assign sum = {1'b0, r_ac} + {1'b0, r_dr};

    always_comb begin
        n_addr = r_addr;
        n_pc   = r_pc;
        n_dr   = r_dr;
        n_ac   = r_ac;
        n_ir   = r_ir;
        n_tr   = r_tr;
        n_inpr = r_inpr;
        n_sc   = r_sc;
        n_opc  = r_opc;
        n_s    = r_s;
        n_fgi  = r_fgi;
        n_fgo  = r_fgo;
        n_ien  = r_ien;
        n_r    = r_r;
        n_i    = r_i;
        n_e    = r_e;
        ov     = 1'b0;
        wr     = '0;
        if (i_fire) begin
            case (i_item.action)
                bcc_pkg::ACT_TICK: begin
                    if (!r_s) begin
                        n_s = r_s;
                    end else if (r_r) begin
                        if (r_sc == bcc_pkg::T0) begin
                            n_addr = 12'd0;
                            n_tr   = {4'd0, r_pc};
                            n_sc   = bcc_pkg::T1;
                        end else if (r_sc == bcc_pkg::T1) begin
                            wr.wr_en = 1'b1;
                            wr.addr  = r_addr;
                            wr.data  = r_tr;
                            n_pc     = 12'd0;
                            n_sc     = bcc_pkg::T2;
                        end else begin
                            n_pc  = r_pc + 12'd1;
                            n_ien = 1'b0;
                            n_r   = 1'b0;
                            n_sc  = bcc_pkg::T0;
                        end
                    end else if (r_sc == bcc_pkg::T0) begin
                        n_addr = r_pc;
                        n_sc   = bcc_pkg::T1;
                    end else if (r_sc == bcc_pkg::T1) begin
                        n_ir = i_rd_data;
                        n_pc = r_pc + 12'd1;
                        n_sc = bcc_pkg::T2;
                    end else if (r_sc == bcc_pkg::T2) begin
                        n_addr = r_ir[11:0];
                        n_opc  = r_ir[14:12];
                        n_i    = r_ir[15];
                        n_sc   = bcc_pkg::T3;
                    end else begin
                        if (r_ien && (r_fgi || r_fgo)) begin
                            n_r = 1'b1;
                        end
                        if (r_opc == bcc_pkg::OP_REG_IO) begin
                            n_sc = bcc_pkg::T0;
                            if (r_i) begin
                                case (r_ir[11:0])
                                    bcc_pkg::IO_IOF: n_ien = 1'b0;
                                    bcc_pkg::IO_ION: n_ien = 1'b1;
                                    bcc_pkg::IO_SKO: if (r_fgo) n_pc = r_pc + 12'd1;
                                    bcc_pkg::IO_SKI: if (r_fgi) n_pc = r_pc + 12'd1;
                                    bcc_pkg::IO_OUT: begin
                                        ov    = 1'b1;
                                        n_fgo = 1'b0;
                                    end
                                    bcc_pkg::IO_INP: begin
                                        n_ac  = {r_ac[15:8], r_inpr};
                                        n_fgi = 1'b0;
                                    end
                                    default: n_sc = bcc_pkg::T0;
                                endcase
                            end else begin
                                case (r_ir[11:0])
                                    bcc_pkg::RR_HLT: n_s = 1'b0;
                                    bcc_pkg::RR_SZE: if (!r_e) n_pc = r_pc + 12'd1;
                                    bcc_pkg::RR_SZA: if (r_ac == 16'd0) n_pc = r_pc + 12'd1;
                                    bcc_pkg::RR_SNA: if (r_ac[15]) n_pc = r_pc + 12'd1;
                                    bcc_pkg::RR_SPA: if (!r_ac[15]) n_pc = r_pc + 12'd1;
                                    bcc_pkg::RR_INC: n_ac = r_ac + 16'd1;
                                    bcc_pkg::RR_CIL: begin
                                        n_e  = r_ac[15];
                                        n_ac = {r_ac[14:0], r_e};
                                    end
                                    bcc_pkg::RR_CIR: begin
                                        n_e  = r_ac[0];
                                        n_ac = {r_e, r_ac[15:1]};
                                    end
                                    bcc_pkg::RR_CME: n_e = !r_e;
                                    bcc_pkg::RR_CMA: n_ac = ~r_ac;
                                    bcc_pkg::RR_CLE: n_e = 1'b0;
                                    bcc_pkg::RR_CLA: n_ac = 16'd0;
                                    default: n_sc = bcc_pkg::T0;
                                endcase
                            end
                        end else if (r_sc == bcc_pkg::T3) begin
                            if (r_i) begin
                                n_addr = i_rd_data[11:0];
                            end
                            n_sc = bcc_pkg::T4;
                        end else begin
                            n_sc = bcc_pkg::T0;
                            case (r_opc)
                                bcc_pkg::OP_AND, bcc_pkg::OP_ADD, bcc_pkg::OP_LDA: begin
                                    if (r_sc == bcc_pkg::T4) begin
                                        n_dr = i_rd_data;
                                        n_sc = bcc_pkg::T5;
                                    end else if (r_sc == bcc_pkg::T5) begin
                                        if (r_opc == bcc_pkg::OP_AND) begin
                                            n_ac = r_ac & r_dr;
                                        end else if (r_opc == bcc_pkg::OP_LDA) begin
                                            n_ac = r_dr;
                                        end else begin
                                            n_e  = sum[16];
                                            n_ac = sum[15:0];
                                        end
                                    end
                                end
                                bcc_pkg::OP_STA: begin
                                    if (r_sc == bcc_pkg::T4) begin
                                        wr.wr_en = 1'b1;
                                        wr.addr  = r_addr;
                                        wr.data  = r_ac;
                                    end
                                end
                                bcc_pkg::OP_BUN: begin
                                    if (r_sc == bcc_pkg::T4) begin
                                        n_pc = r_addr;
                                    end
                                end
                                bcc_pkg::OP_BSA: begin
                                    if (r_sc == bcc_pkg::T4) begin
                                        wr.wr_en = 1'b1;
                                        wr.addr  = r_addr;
                                        wr.data  = {4'd0, r_pc};
                                        n_addr   = r_addr + 12'd1;
                                        n_sc     = bcc_pkg::T5;
                                    end else if (r_sc == bcc_pkg::T5) begin
                                        n_pc = r_addr;
                                    end
                                end
                                bcc_pkg::OP_ISZ: begin
                                    if (r_sc == bcc_pkg::T4) begin
                                        n_dr = i_rd_data;
                                        n_sc = bcc_pkg::T5;
                                    end else if (r_sc == bcc_pkg::T5) begin
                                        n_dr = r_dr + 16'd1;
                                        n_sc = bcc_pkg::T6;
                                    end else if (r_sc == bcc_pkg::T6) begin
                                        wr.wr_en = 1'b1;
                                        wr.addr  = r_addr;
                                        wr.data  = r_dr;
                                        if (r_dr == 16'd0) begin
                                            n_pc = r_pc + 12'd1;
                                        end
                                    end
                                end
                                default: n_sc = bcc_pkg::T0;
                            endcase
                        end
                    end
                end
                bcc_pkg::ACT_LOAD: begin
                    wr.wr_en = 1'b1;
                    wr.addr  = i_item.mem_addr;
                    wr.data  = i_item.mem_data;
                end
                bcc_pkg::ACT_INPUT: begin
                    n_inpr = i_item.in_char;
                    n_fgi  = 1'b1;
                end
                bcc_pkg::ACT_OUT_FREE: n_fgo = 1'b1;
                default: n_s = r_s;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
            r_pc   <= '0;
            r_dr   <= '0;
            r_ac   <= '0;
            r_ir   <= '0;
            r_tr   <= '0;
            r_inpr <= '0;
            r_sc   <= bcc_pkg::T0;
            r_opc  <= '0;
            r_s    <= 1'b1;
            r_fgi  <= 1'b0;
            r_fgo  <= 1'b0;
            r_ien  <= 1'b0;
            r_r    <= 1'b0;
            r_i    <= 1'b0;
            r_e    <= 1'b0;
        end else begin
            r_addr <= n_addr;
            r_pc   <= n_pc;
            r_dr   <= n_dr;
            r_ac   <= n_ac;
            r_ir   <= n_ir;
            r_tr   <= n_tr;
            r_inpr <= n_inpr;
            r_sc   <= n_sc;
            r_opc  <= n_opc;
            r_s    <= n_s;
            r_fgi  <= n_fgi;
            r_fgo  <= n_fgo;
            r_ien  <= n_ien;
            r_r    <= n_r;
            r_i    <= n_i;
            r_e    <= n_e;
        end
    end

    always_comb begin
        o_result.halted       = !n_s;
        o_result.out_valid    = ov;
        o_result.out_char     = ov ? r_ac[7:0] : 8'd0;
        o_result.read_data    = (i_item.action == bcc_pkg::ACT_READ) ? i_rd_data : 16'd0;
        o_result.prog_counter = n_pc;
        o_result.accum        = n_ac;
        o_result.extend_bit   = n_e;
        o_result.int_enable   = n_ien;
    end

    assign o_mem_wr    = wr;
    assign o_next_addr = n_addr;

endmodule

// File: design/basic_computer_control_step.sv
// Top level of the basic computer control step block: handshakes, item and result registers.
//
// One transaction per clock is sustained while results are taken. A transaction is taken
// into the item register, executed against the architectural registers and the word that the
// memory read port returned for it once the result register is free or being emptied, and
// shown in the result register; while a result waits, the input side accepts only into an
// empty item register. Each transaction makes one memory read and at most one memory write;
// the read address is issued as the transaction is accepted: the item's own address for a
// read, else the address register the preceding transaction leaves, with same-cycle writes
// bypassed to it. After reset memory is swept to zero, one word a cycle, while ready stays low.
module basic_computer_control_step #(
    parameter int MEM_WORDS = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_action,
    input  logic [11:0] i_mem_addr,
    input  logic [15:0] i_mem_data,
    input  logic [7:0]  i_in_char,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_halted,
    output logic        o_out_valid,
    output logic [7:0]  o_out_char,
    output logic [15:0] o_read_data,
    output logic [11:0] o_prog_counter,
    output logic [15:0] o_accum,
    output logic        o_extend_bit,
    output logic        o_int_enable
);
    logic             r_in_valid;
    bcc_pkg::t_item   r_in;
    logic             r_out_valid;
    bcc_pkg::t_result r_out;

    logic             accept;
    logic             fire;
    logic             mem_busy;
    logic [15:0]      rd_data;
    logic [11:0]      next_addr;
    bcc_pkg::t_result result;
    bcc_pkg::t_mem_wr mem_wr;
    bcc_pkg::t_mem_req mem_req;

    assign fire    = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !mem_busy && (!r_in_valid || fire);
    assign accept  = i_valid && o_ready;

    always_comb begin
        mem_req.rd_en   = accept;
        mem_req.rd_addr = (i_action == bcc_pkg::ACT_READ) ? i_mem_addr : next_addr;
        mem_req.wr_en   = mem_wr.wr_en;
        mem_req.wr_addr = mem_wr.addr;
        mem_req.wr_data = mem_wr.data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in.action   <= i_action;
            r_in.mem_addr <= i_mem_addr;
            r_in.mem_data <= i_mem_data;
            r_in.in_char  <= i_in_char;
        end
        if (fire) begin
            r_out <= result;
        end
    end

    bcc_mem #(
        .MEM_WORDS(MEM_WORDS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (mem_req),
        .o_rd_data (rd_data),
        .o_busy    (mem_busy)
    );

    bcc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_item      (r_in),
        .i_rd_data   (rd_data),
        .o_result    (result),
        .o_mem_wr    (mem_wr),
        .o_next_addr (next_addr)
    );

    assign o_valid        = r_out_valid;
    assign o_halted       = r_out.halted;
    assign o_out_valid    = r_out.out_valid;
    assign o_out_char     = r_out.out_char;
    assign o_read_data    = r_out.read_data;
    assign o_prog_counter = r_out.prog_counter;
    assign o_accum        = r_out.accum;
    assign o_extend_bit   = r_out.extend_bit;
    assign o_int_enable   = r_out.int_enable;

endmodule
